/* sv/rrte_pkg.sv */
// package: shared types and constants of the recording rate and time estimator
`timescale 1ns / 1ps
`default_nettype none
package rrte_pkg;

   localparam int DIV_WIDTH  = 64;
   localparam int REM_WIDTH  = 32;
   localparam int STEP_WIDTH = $clog2(DIV_WIDTH + 1);

   localparam logic [31:0] SAT_TIME       = 32'h7FFF_FFFF;
   localparam logic [17:0] FULL_4GB_UNITS = 18'd131072;
   localparam logic [31:0] TENTHS_PER_TICK = 32'd10;

   // x / 10 is (x * RECIP_TEN) >> 35 for any 32-bit x
   localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;

   // configuration register indexes
   localparam logic [1:0] CSR_DISPLAY_MODE = 2'd0;
   localparam logic [1:0] CSR_CLUSTER_KIB  = 2'd1;
   localparam logic [1:0] CSR_WARN_SECONDS = 2'd2;

   // display modes
   localparam logic [1:0] MODE_OFF     = 2'd0;
   localparam logic [1:0] MODE_ELAPSED = 2'd1;
   localparam logic [1:0] MODE_CARD    = 2'd2;
   localparam logic [1:0] MODE_MIN     = 2'd3;

   // iteration counts of the divider for each quotient
   localparam logic [STEP_WIDTH-1:0] STEPS_CARD = STEP_WIDTH'(64);
   localparam logic [STEP_WIDTH-1:0] STEPS_4GB  = STEP_WIDTH'(50);
   localparam logic [STEP_WIDTH-1:0] STEPS_32   = STEP_WIDTH'(32);

   typedef struct packed {
      logic                  start;
      logic [STEP_WIDTH-1:0] steps;
   } div_req_type;

endpackage
`default_nettype wire

/* sv/rrte_mul.sv */
// module: shared 32x32 multiplier with registered product
`timescale 1ns / 1ps
`default_nettype none
module rrte_mul (
   input  wire logic        clock,
   input  wire logic [31:0] mul_a,
   input  wire logic [31:0] mul_b,
   output logic      [63:0] mul_p
);

   logic [63:0] p_ff;
   logic [63:0] p_in;

   assign p_in  = {32'b0, mul_a} * {32'b0, mul_b};
   assign mul_p = p_ff;

   always_ff @(posedge clock) begin
      p_ff <= p_in;
   end

endmodule
`default_nettype wire

/* sv/rrte_div.sv */
// module: shared restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module rrte_div (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire rrte_pkg::div_req_type                div_req,
   input  wire logic [rrte_pkg::DIV_WIDTH-1:0]       dividend,
   input  wire logic [rrte_pkg::REM_WIDTH-1:0]       divisor,
   output logic                                      div_done,
   output logic      [rrte_pkg::DIV_WIDTH-1:0]       quotient
);

   logic                                 busy_ff, busy_in;
   logic                                 done_ff, done_in;
   logic [rrte_pkg::STEP_WIDTH-1:0]      cnt_ff, cnt_in;
   logic [rrte_pkg::DIV_WIDTH-1:0]       dvd_ff, dvd_in;
   logic [rrte_pkg::REM_WIDTH-1:0]       dvs_ff, dvs_in;
   logic [rrte_pkg::REM_WIDTH-1:0]       rem_ff, rem_in;
   logic [rrte_pkg::DIV_WIDTH-1:0]       quo_ff, quo_in;
   logic [rrte_pkg::REM_WIDTH:0]         trial;
   logic [rrte_pkg::REM_WIDTH:0]         diff;
   logic                                 ge;

   // remainder stays below the divisor, so the trial fits one extra bit
   assign trial = {rem_ff, dvd_ff[rrte_pkg::DIV_WIDTH-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign ge    = ~diff[rrte_pkg::REM_WIDTH];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = div_req.steps;
         dvd_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in = ge ? diff[rrte_pkg::REM_WIDTH-1:0] : trial[rrte_pkg::REM_WIDTH-1:0];
         quo_in = {quo_ff[rrte_pkg::DIV_WIDTH-2:0], ge};
         dvd_in = {dvd_ff[rrte_pkg::DIV_WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - rrte_pkg::STEP_WIDTH'(1);
         if (cnt_ff == rrte_pkg::STEP_WIDTH'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign div_done = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

/* sv/recording_rate_and_time_estimator_core.sv */
// top level: sequencer, state and output register of the rate and time estimator
// a word taken while not recording goes straight to ST_FINISH; a recording word first passes ST_MUL_FU,
//    ST_MUL_LO, ST_MUL_HI and ST_MUL_4G and the shared divider (card 64, 4 GB 50, average 32
//    iterations); ST_FINISH waits for a free output register, and a new word is taken only in ST_IDLE;
//    seconds come from a reciprocal multiply during the average division
// a new word is taken while a finished result still waits in the output register
// reset (synchronous): registers to 3 / 32 / 120, clip state cleared, no result pending
`timescale 1ns / 1ps
`default_nettype none
module recording_rate_and_time_estimator_core (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   // is_recording [0], total_bytes [32:1], free_clusters [64:33], zero fill
   input  wire logic [71:0]   req_tdata,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   // elapsed_seconds [28:0], instant_mbps [43:29], average_rate [74:44],
   // shown_seconds [106:75], low_time_warning [107], estimate_valid [108], zero fill
   output logic      [111:0]  rsp_tdata,
   input  wire logic          csr_we,
   input  wire logic [1:0]    csr_index,
   input  wire logic [15:0]   csr_wdata
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_FU,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_MUL_4G,
      ST_DIV_CARD,
      ST_DIV_4G,
      ST_DIV_AVG,
      ST_FINISH
   } state_type;

   state_type     state_ff, state_in;
   logic [1:0]    mode_ff, mode_in;
   logic [10:0]   ckib_ff, ckib_in;
   logic [15:0]   warn_ff, warn_in;
   logic [31:0]   prior_ff, prior_in;
   logic [31:0]   elapsed_ff, elapsed_in;
   logic [16:0]   wu_ff, wu_in;
   logic [31:0]   free_ff, free_in;
   logic          rec_ff, rec_in;
   logic [14:0]   mbps_ff, mbps_in;
   logic [5:0]    fu_hi_ff, fu_hi_in;
   logic [63:0]   lo_ff, lo_in;
   logic          ovf_ff, ovf_in;
   logic [31:0]   card_ff, card_in;
   logic [31:0]   t4g_ff, t4g_in;
   logic [30:0]   avg_ff, avg_in;
   logic [28:0]   sec_ff, sec_in;
   logic          rsp_tvalid_ff, rsp_tvalid_in;
   logic [111:0]  rsp_tdata_ff, rsp_tdata_in;

   logic [31:0]   mul_a, mul_b;
   logic [63:0]   mul_p;
   rrte_pkg::div_req_type div_req;
   logic [63:0]   div_dividend;
   logic [31:0]   div_divisor;
   logic          div_done;
   logic [63:0]   div_q;

   logic          req_fire;
   logic [31:0]   in_total, in_free;
   logic          in_rec;
   logic [31:0]   diff, mag;
   logic [17:0]   units4;
   logic [31:0]   wu10;
   logic [69:0]   card_sum;
   logic [31:0]   avg_num;
   logic          wu_zero;
   logic          q_big;
   logic [31:0]   shown;
   logic          warn_flag;
   logic          slot_free;

   rrte_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   rrte_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .div_done (div_done),
      .quotient (div_q)
   );

   assign in_rec   = req_tdata[0];
   assign in_total = req_tdata[32:1];
   assign in_free  = req_tdata[64:33];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign slot_free  = ~rsp_tvalid_ff | rsp_tready;

   // byte delta from halved counters, magnitude over 2^17 gives Mbit/s
   assign diff = ({1'b0, in_total[31:1]} - {1'b0, prior_ff[31:1]}) << 1;
   assign mag  = diff[31] ? (32'd0 - diff) : diff;

   assign units4   = rrte_pkg::FULL_4GB_UNITS - {1'b0, wu_ff};
   assign wu10     = {12'b0, wu_ff, 3'b0} + {14'b0, wu_ff, 1'b0};
   assign card_sum = {6'b0, lo_ff} + {mul_p[37:0], 32'b0};
   assign avg_num  = ({13'b0, wu_ff, 2'b0} + {15'b0, wu_ff}) >> 1;
   assign wu_zero  = (wu_ff == 17'd0);
   assign q_big    = (div_q[63:31] != 33'd0);

   always_comb begin
      case (mode_ff)
         rrte_pkg::MODE_ELAPSED: shown = {3'b0, sec_ff};
         rrte_pkg::MODE_CARD:    shown = card_ff;
         rrte_pkg::MODE_MIN:     shown = (t4g_ff < card_ff) ? t4g_ff : card_ff;
         default:                shown = 32'd0;
      endcase
   end

   assign warn_flag = (t4g_ff < {16'b0, warn_ff});

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      ckib_in       = ckib_ff;
      warn_in       = warn_ff;
      prior_in      = prior_ff;
      elapsed_in    = elapsed_ff;
      wu_in         = wu_ff;
      free_in       = free_ff;
      rec_in        = rec_ff;
      mbps_in       = mbps_ff;
      fu_hi_in      = fu_hi_ff;
      lo_in         = lo_ff;
      ovf_in        = ovf_ff;
      card_in       = card_ff;
      t4g_in        = t4g_ff;
      avg_in        = avg_ff;
      sec_in        = sec_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;

      mul_a         = elapsed_ff;
      mul_b         = {14'b0, units4};
      div_req.start = 1'b0;
      div_req.steps = rrte_pkg::STEPS_32;
      div_dividend  = {elapsed_ff, 32'b0};
      div_divisor   = rrte_pkg::TENTHS_PER_TICK;

      if (csr_we) begin
         case (csr_index)
            rrte_pkg::CSR_DISPLAY_MODE: mode_in = csr_wdata[1:0];
            rrte_pkg::CSR_CLUSTER_KIB:  ckib_in = csr_wdata[10:0];
            rrte_pkg::CSR_WARN_SECONDS: warn_in = csr_wdata;
            default: ;
         endcase
      end

      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               rec_in = in_rec;
               if (in_rec) begin
                  elapsed_in = elapsed_ff + rrte_pkg::TENTHS_PER_TICK;
                  mbps_in    = mag[31:17];
                  prior_in   = in_total;
                  wu_in      = in_total[31:15];
                  free_in    = in_free;
                  state_in   = ST_MUL_FU;
               end else begin
                  elapsed_in = 32'd0;
                  state_in   = ST_FINISH;
               end
            end
         end
         ST_MUL_FU: begin
            mul_a    = free_ff;
            mul_b    = {21'b0, ckib_ff};
            state_in = ST_MUL_LO;
         end
         ST_MUL_LO: begin
            // free space in 32 KiB units is product >> 5, low word first
            mul_b    = mul_p[36:5];
            fu_hi_in = mul_p[42:37];
            state_in = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            mul_b    = {26'b0, fu_hi_ff};
            lo_in    = mul_p;
            state_in = ST_MUL_4G;
         end
         ST_MUL_4G: begin
            ovf_in        = (card_sum[69:64] != 6'd0);
            div_req.start = 1'b1;
            div_req.steps = rrte_pkg::STEPS_CARD;
            div_dividend  = card_sum[63:0];
            div_divisor   = wu10;
            state_in      = ST_DIV_CARD;
         end
         ST_DIV_CARD: begin
            if (div_done) begin
               card_in       = (wu_zero || ovf_ff || q_big) ? rrte_pkg::SAT_TIME
                                                            : div_q[31:0];
               div_req.start = 1'b1;
               div_req.steps = rrte_pkg::STEPS_4GB;
               div_dividend  = {mul_p[49:0], 14'b0};
               div_divisor   = wu10;
               state_in      = ST_DIV_4G;
            end
         end
         ST_DIV_4G: begin
            if (div_done) begin
               t4g_in        = (wu_zero || q_big) ? rrte_pkg::SAT_TIME : div_q[31:0];
               div_req.start = 1'b1;
               div_req.steps = rrte_pkg::STEPS_32;
               div_dividend  = {avg_num, 32'b0};
               div_divisor   = elapsed_ff;
               state_in      = ST_DIV_AVG;
            end
         end
         ST_DIV_AVG: begin
            // elapsed seconds by reciprocal multiply while the divider runs
            mul_b = rrte_pkg::RECIP_TEN;
            if (div_done) begin
               avg_in   = (elapsed_ff == 32'd0) ? rrte_pkg::SAT_TIME[30:0] : div_q[30:0];
               sec_in   = mul_p[63:35];
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               rsp_tvalid_in = 1'b1;
               if (rec_ff) begin
                  rsp_tdata_in = {3'b0, ~wu_zero, warn_flag, shown, avg_ff, mbps_ff, sec_ff};
               end else begin
                  rsp_tdata_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         mode_ff       <= rrte_pkg::MODE_MIN;
         ckib_ff       <= 11'd32;
         warn_ff       <= 16'd120;
         prior_ff      <= 32'd0;
         elapsed_ff    <= 32'd0;
         wu_ff         <= 17'd0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mode_ff       <= mode_in;
         ckib_ff       <= ckib_in;
         warn_ff       <= warn_in;
         prior_ff      <= prior_in;
         elapsed_ff    <= elapsed_in;
         wu_ff         <= wu_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      free_ff      <= free_in;
      rec_ff       <= rec_in;
      mbps_ff      <= mbps_in;
      fu_hi_ff     <= fu_hi_in;
      lo_ff        <= lo_in;
      ovf_ff       <= ovf_in;
      card_ff      <= card_in;
      t4g_ff       <= t4g_in;
      avg_ff       <= avg_in;
      sec_ff       <= sec_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule
`default_nettype wire

/* sim/recording_rate_and_time_estimator_core_tb.sv */
// testbench: recording rate and time estimator core against a cycle-free predictor
`timescale 1ns / 1ps
module recording_rate_and_time_estimator_core_tb;

   localparam logic [1:0] CSR_UNUSED = 2'd3;

   // result word, packed in the same bit order as rsp_tdata
   typedef struct packed {
      logic        estimate_valid;
      logic        low_time_warning;
      logic [31:0] shown_seconds;
      logic [30:0] average_rate;
      logic [14:0] instant_mbps;
      logic [28:0] elapsed_seconds;
   } rate_result_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [71:0]   req_tdata = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [111:0]  rsp_tdata;
   logic          csr_we = 1'b0;
   logic [1:0]    csr_index = '0;
   logic [15:0]   csr_wdata = '0;

   recording_rate_and_time_estimator_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor copy of registers and clip state
   logic [1:0]  cfg_mode = rrte_pkg::MODE_MIN;
   logic [10:0] cfg_cluster_kib = 11'd32;
   logic [15:0] cfg_warn = 16'd120;
   logic [31:0] clip_prior_total = '0;
   logic [31:0] clip_tenths = '0;
   logic [16:0] clip_units = '0;

   rate_result_type pending_results[$];

   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned stall_left = 0;
   int unsigned mismatch_count = 0;
   int unsigned words_sent = 0;
   int unsigned recording_words = 0;
   int unsigned results_checked = 0;
   int unsigned warnings_seen = 0;
   int unsigned valid_seen = 0;

   function automatic logic [31:0] clip_time(input longint unsigned tenths,
                                             input longint unsigned units,
                                             input longint unsigned per);
      longint unsigned quot;
      if (per == 0) return rrte_pkg::SAT_TIME;
      if (units != 0 && tenths > 64'hFFFF_FFFF_FFFF_FFFF / units) return rrte_pkg::SAT_TIME;
      quot = tenths * units / per / 10;
      return (quot > 64'(rrte_pkg::SAT_TIME)) ? rrte_pkg::SAT_TIME : quot[31:0];
   endfunction

   function automatic rate_result_type predict_estimate(input bit rec,
                                                        input logic [31:0] total,
                                                        input logic [31:0] free_cl);
      rate_result_type r;
      logic [31:0] diff;
      logic [31:0] mag;
      logic [31:0] card;
      logic [31:0] t4gb;
      logic [31:0] shown;
      longint unsigned free_units;
      longint unsigned avg;
      r = '0;
      if (!rec) begin
         clip_tenths = '0;
         return r;
      end
      clip_tenths = clip_tenths + 32'd10;
      // bit 0 of the counter is dropped before the delta is taken
      diff = ((total >> 1) - (clip_prior_total >> 1)) << 1;
      mag = diff[31] ? (32'd0 - diff) : diff;
      clip_prior_total = total;
      clip_units = total[31:15];
      free_units = 64'(free_cl) * 64'(cfg_cluster_kib) / 32;
      card = clip_time(64'(clip_tenths), free_units, 64'(clip_units));
      t4gb = clip_time(64'(clip_tenths), 64'(rrte_pkg::FULL_4GB_UNITS) - 64'(clip_units),
                       64'(clip_units));
      if (clip_tenths == 0)
         avg = 64'(rrte_pkg::SAT_TIME);
      else
         avg = 64'(clip_units) * 2560 / 1024 / 64'(clip_tenths);
      case (cfg_mode)
         rrte_pkg::MODE_ELAPSED: shown = clip_tenths / 10;
         rrte_pkg::MODE_CARD:    shown = card;
         rrte_pkg::MODE_MIN:     shown = (t4gb < card) ? t4gb : card;
         default:                shown = '0;
      endcase
      r.elapsed_seconds  = 29'(clip_tenths / 10);
      r.instant_mbps     = 15'((mag / 1024) * 8 / 1024);
      r.average_rate     = avg[30:0];
      r.shown_seconds    = shown;
      r.low_time_warning = (t4gb < 32'(cfg_warn));
      r.estimate_valid   = (clip_units != 0);
      return r;
   endfunction

   // result side: random stalls, now and then a long one
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(99) < recv_stall_pct) begin
         rsp_tready <= 1'b0;
         if ($urandom_range(49) == 0) stall_left <= $urandom_range(250, 20);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      rate_result_type want;
      rate_result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("result word with no expectation waiting: %h", rsp_tdata);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            got = rate_result_type'(rsp_tdata[108:0]);
            check_field("elapsed_seconds", 32'(want.elapsed_seconds), 32'(got.elapsed_seconds));
            check_field("instant_mbps", 32'(want.instant_mbps), 32'(got.instant_mbps));
            check_field("average_rate", 32'(want.average_rate), 32'(got.average_rate));
            check_field("shown_seconds", want.shown_seconds, got.shown_seconds);
            check_field("low_time_warning", 32'(want.low_time_warning),
                        32'(got.low_time_warning));
            check_field("estimate_valid", 32'(want.estimate_valid), 32'(got.estimate_valid));
            results_checked++;
            if (got.low_time_warning) warnings_seen++;
            if (got.estimate_valid) valid_seen++;
         end
      end
   end

   // valid stays high when the next word follows right away
   task automatic send_word(input bit rec, input logic [31:0] total, input logic [31:0] free_cl);
      int unsigned gap;
      gap = 0;
      if ($urandom_range(99) < send_idle_pct)
         gap = ($urandom_range(7) == 0) ? $urandom_range(250, 20) : $urandom_range(8, 1);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {7'd0, free_cl, total, rec};
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(predict_estimate(rec, total, free_cl));
      words_sent++;
      if (rec) recording_words++;
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         rrte_pkg::CSR_DISPLAY_MODE: cfg_mode = value[1:0];
         rrte_pkg::CSR_CLUSTER_KIB:  cfg_cluster_kib = value[10:0];
         rrte_pkg::CSR_WARN_SECONDS: cfg_warn = value;
         default: ;
      endcase
   endtask

   // reset values: nothing written yet, normal clip, near 4 GB, wrap and half-range delta
   task automatic test_directed_basics();
      send_word(1'b0, 32'd0, 32'd0);
      send_word(1'b1, 32'd0, 32'd1000);
      send_word(1'b1, 32'd32768 * 1000, 32'd100000);
      send_word(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(1'b1, 32'h0010_0000, 32'd0);
      send_word(1'b1, 32'h8010_0000, 32'd500);
      send_word(1'b0, 32'h1234_5678, 32'hFFFF_FFFF);
      send_word(1'b1, 32'h8010_0001, 32'd12345);
   endtask

   task automatic test_display_modes();
      logic [1:0] modes [4];
      logic [31:0] bytes;
      modes = '{rrte_pkg::MODE_OFF, rrte_pkg::MODE_ELAPSED, rrte_pkg::MODE_CARD,
                rrte_pkg::MODE_MIN};
      bytes = 32'h0200_0000;
      foreach (modes[i]) begin
         settle();
         write_reg(rrte_pkg::CSR_DISPLAY_MODE, 16'(modes[i]));
         repeat (2) begin
            bytes += 32'd20_000_000;
            send_word(1'b1, bytes, 32'd400_000);
         end
      end
   endtask

   task automatic test_register_extremes();
      settle();
      write_reg(rrte_pkg::CSR_CLUSTER_KIB, 16'd0);
      write_reg(rrte_pkg::CSR_WARN_SECONDS, 16'hFFFF);
      write_reg(rrte_pkg::CSR_DISPLAY_MODE, 16'hFFFF);
      send_word(1'b1, 32'h0400_0000, 32'hFFFF_FFFF);
      send_word(1'b1, 32'hF000_0000, 32'd77);
      settle();
      write_reg(rrte_pkg::CSR_CLUSTER_KIB, 16'hFFFF);
      write_reg(rrte_pkg::CSR_WARN_SECONDS, 16'd0);
      write_reg(rrte_pkg::CSR_DISPLAY_MODE, 16'(rrte_pkg::MODE_CARD));
      send_word(1'b1, 32'hF000_8000, 32'hFFFF_FFFF);
      send_word(1'b1, 32'hF100_0000, 32'd3);
      settle();
      write_reg(rrte_pkg::CSR_CLUSTER_KIB, 16'd1);
      send_word(1'b1, 32'hF200_0000, 32'd1_000_000);
      settle();
      write_reg(rrte_pkg::CSR_CLUSTER_KIB, 16'd1024);
      // the spare index must leave every register alone
      write_reg(CSR_UNUSED, 16'hA5A5);
      send_word(1'b1, 32'hF300_0000, 32'd1_000_000);
   endtask

   // clips of growing byte counts with a few stop ticks and some noise words
   task automatic test_random_clips(input int unsigned idle_pct, input int unsigned stall_pct,
                                    input int unsigned word_count);
      int unsigned sent;
      int unsigned clip_len;
      logic [31:0] bytes;
      logic [31:0] free_cl;
      settle();
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      write_reg(rrte_pkg::CSR_DISPLAY_MODE, 16'($urandom));
      case ($urandom_range(4))
         0: write_reg(rrte_pkg::CSR_CLUSTER_KIB, 16'd1);
         1: write_reg(rrte_pkg::CSR_CLUSTER_KIB, 16'd1024);
         2: write_reg(rrte_pkg::CSR_CLUSTER_KIB, 16'd2047);
         3: write_reg(rrte_pkg::CSR_CLUSTER_KIB, 16'd32);
         default: write_reg(rrte_pkg::CSR_CLUSTER_KIB, 16'($urandom));
      endcase
      case ($urandom_range(3))
         0: write_reg(rrte_pkg::CSR_WARN_SECONDS, 16'd0);
         1: write_reg(rrte_pkg::CSR_WARN_SECONDS, 16'hFFFF);
         2: write_reg(rrte_pkg::CSR_WARN_SECONDS, 16'($urandom_range(600)));
         default: write_reg(rrte_pkg::CSR_WARN_SECONDS, 16'($urandom));
      endcase
      sent = 0;
      while (sent < word_count) begin
         if ($urandom_range(9) == 0) begin
            send_word(1'($urandom), $urandom, $urandom);
            sent++;
         end else begin
            case ($urandom_range(3))
               0: bytes = 32'd0;
               1: bytes = $urandom;
               2: bytes = 32'hFFFF_FFFF - $urandom_range(50_000_000);
               default: bytes = $urandom_range(1 << 20);
            endcase
            free_cl = ($urandom_range(3) == 0) ? $urandom : $urandom_range(2_000_000);
            clip_len = $urandom_range(40, 1);
            for (int k = 0; k < clip_len && sent < word_count; k++) begin
               bytes += ($urandom_range(19) == 0) ? $urandom : $urandom_range(30_000_000);
               if (free_cl > 1000) free_cl -= $urandom_range(1000);
               send_word(1'b1, bytes, free_cl);
               sent++;
            end
            repeat ($urandom_range(2, 1)) begin
               send_word(1'b0, $urandom, $urandom);
               sent++;
            end
         end
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_directed_basics();
      test_display_modes();
      test_register_extremes();
      test_random_clips(0, 0, 206);
      test_random_clips(48, 0, 206);
      test_random_clips(0, 48, 206);
      test_random_clips(6, 6, 206);
      settle();
      $display("covered %0d words (%0d recording) under four idle and stall mixes",
               words_sent, recording_words);
      $display("checked %0d results: %0d valid estimates, %0d low time warnings",
               results_checked, valid_seen, warnings_seen);
      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("timeout with %0d results still pending", pending_results.size());
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
